// ===== rtl/rc_channels_to_sbus_frame_defines.svh =====
// Assertion macros shared by the frame encoder.
`ifndef RC_CHANNELS_TO_SBUS_FRAME_DEFINES_SVH
`define RC_CHANNELS_TO_SBUS_FRAME_DEFINES_SVH

// same-cycle implication, sampled on clk, off while in reset
`define RCSB_ASSERT_NOW(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off while in reset
`define RCSB_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/rcsb_pkg.sv =====
// Shared types and constants of the SBUS frame encoder.
package rcsb_pkg;

    localparam int FRAME_BYTES = 25;
    localparam int POS_W       = $clog2(FRAME_BYTES);
    localparam int CHAN_W      = 11;
    localparam int ANALOG_CH   = 4;
    localparam int PACKED_CH   = 8;
    localparam int PACK_W      = PACKED_CH * CHAN_W;
    localparam int FLAG_INDEX  = 23;
    localparam int PROD_W      = 18;
    localparam int RECIP_W     = 19;
    localparam int QPROD_W     = PROD_W + RECIP_W;
    localparam int RECIP_SHIFT = 25;

    localparam logic [PROD_W-1:0]  SCALE_MUL  = 18'd107;
    localparam logic [PROD_W-1:0]  SCALE_SUB  = 18'd10618;
    // ceil(2^25 / 100): exact floor division for any dividend below 2^18
    localparam logic [RECIP_W-1:0] RECIP_MUL  = 19'd335545;
    localparam logic [CHAN_W-1:0]  CHAN_MAX   = 11'd2047;
    localparam logic [CHAN_W-1:0]  SWITCH_ON  = 11'd1792;
    localparam logic [CHAN_W-1:0]  SWITCH_OFF = 11'd192;

    localparam logic [7:0] SYNC_RESET = 8'd15;
    localparam logic [7:0] MASK_RESET = 8'd4;

    typedef enum logic [0:0] {
        CFG_SYNC_BYTE = 1'b0,
        CFG_LOST_MASK = 1'b1
    } cfg_index_t;

    typedef struct packed {
        logic [ANALOG_CH-1:0][PROD_W-1:0] prod;
        logic [ANALOG_CH-1:0]             sw;
        logic                             lost;
    } front_t;

    typedef struct packed {
        logic [ANALOG_CH-1:0][CHAN_W-1:0] chan;
        logic [ANALOG_CH-1:0]             sw;
        logic                             lost;
    } chan_t;

    typedef struct packed {
        logic             busy;
        logic [POS_W-1:0] pos;
    } ser_status_t;

endpackage

// ===== rtl/rcsb_if.sv =====
// Valid/ready channel interfaces for radio packets and frame bytes.
interface rcsb_pkt_if;
    logic       valid;
    logic       ready;
    logic [7:0] chan_byte_0;
    logic [7:0] chan_byte_1;
    logic [7:0] chan_byte_2;
    logic [7:0] chan_byte_3;
    logic [7:0] chan_byte_4;
    logic [7:0] chan_byte_5;
    logic       frame_lost;

    modport source (
        output valid, chan_byte_0, chan_byte_1, chan_byte_2,
               chan_byte_3, chan_byte_4, chan_byte_5, frame_lost,
        input  ready
    );
    modport sink (
        input  valid, chan_byte_0, chan_byte_1, chan_byte_2,
               chan_byte_3, chan_byte_4, chan_byte_5, frame_lost,
        output ready
    );
endinterface

interface rcsb_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last_byte;

    modport source (output valid, out_byte, last_byte, input ready);
    modport sink   (input valid, out_byte, last_byte, output ready);
endinterface

// ===== rtl/rc_channels_to_sbus_frame.sv =====
// Top level of the radio-packet to SBUS frame encoder.
// Each accepted packet yields one 25-byte SBUS frame on frm, one byte per word,
// the last marked by last_byte. The byte serialiser sends one word per cycle
// while frm.ready holds; the next packet is taken as the last byte of a frame
// leaves the serialiser. After acceptance a packet passes the unpack, reciprocal
// multiply, clamp, frame load and output registers in turn. Configuration is
// sampled when a frame is loaded into the serialiser.
`include "rc_channels_to_sbus_frame_defines.svh"

module rc_channels_to_sbus_frame
    import rcsb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    rcsb_pkt_if.sink    pkt,
    rcsb_byte_if.source frm,
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [7:0]  cfg_wdata
);

    logic        pkt_accept;
    logic [7:0]  sync_byte_reg;
    logic [7:0]  lost_mask_reg;
    logic        fr_valid;
    logic        fr_ready;
    front_t      fr_data;
    logic        ch_valid;
    logic        ch_ready;
    chan_t       ch_data;
    ser_status_t ser_status;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_byte_reg <= SYNC_RESET;
            lost_mask_reg <= MASK_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_SYNC_BYTE: sync_byte_reg <= cfg_wdata;
                CFG_LOST_MASK: lost_mask_reg <= cfg_wdata;
                default:       sync_byte_reg <= sync_byte_reg;
            endcase
        end
    end

    assign pkt_accept = pkt.valid && pkt.ready;

    rcsb_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .pkt      (pkt),
        .st_valid (fr_valid),
        .st_ready (fr_ready),
        .st_data  (fr_data)
    );

    rcsb_scale u_scale (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fr_valid),
        .in_ready  (fr_ready),
        .in_data   (fr_data),
        .out_valid (ch_valid),
        .out_ready (ch_ready),
        .out_data  (ch_data)
    );

    rcsb_framer u_framer (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (ch_valid),
        .in_ready       (ch_ready),
        .in_data        (ch_data),
        .sync_byte      (sync_byte_reg),
        .lost_flag_mask (lost_mask_reg),
        .frm            (frm),
        .status         (ser_status)
    );

    `RCSB_ASSERT_NEXT(a_accept_fills_front, pkt_accept, fr_valid, "accepted packet lost at unpack")
    `RCSB_ASSERT_NOW(a_last_ends_frame, frm.valid && frm.last_byte, ser_status.pos == '0, "last byte sent with serialiser mid-frame")
    `RCSB_ASSERT_NEXT(a_stalled_frame_held, ch_valid && !ch_ready, ch_valid, "scaled frame dropped while serialiser busy")
    `RCSB_ASSERT_NOW(a_idle_at_start, !ser_status.busy, ser_status.pos == '0, "idle serialiser not at frame start")

endmodule

// ===== rtl/rcsb_front.sv =====
// Unpack stage: channel extraction and the 107x product.
module rcsb_front
    import rcsb_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    rcsb_pkt_if.sink   pkt,
    output logic       st_valid,
    input  logic       st_ready,
    output front_t     st_data
);

    logic                             valid_reg;
    logic                             advance;
    front_t                           data_reg;
    front_t                           data_next;
    logic [ANALOG_CH-1:0][CHAN_W-1:0] raw;

    assign advance   = !valid_reg || st_ready;
    assign pkt.ready = advance;

    always_comb
    begin
        raw[0] = {pkt.chan_byte_1[2:0], pkt.chan_byte_0};
        raw[1] = {pkt.chan_byte_2[6:0], pkt.chan_byte_1[7:4]};
        raw[2] = {pkt.chan_byte_4[2:0], pkt.chan_byte_3};
        raw[3] = {pkt.chan_byte_5[6:0], pkt.chan_byte_4[7:4]};
        for (int i = 0; i < ANALOG_CH; i++)
        begin
            data_next.prod[i] = {{(PROD_W-CHAN_W){1'b0}}, raw[i]} * SCALE_MUL;
        end
        data_next.sw   = {pkt.chan_byte_5[7], pkt.chan_byte_4[3],
                          pkt.chan_byte_2[7], pkt.chan_byte_1[3]};
        data_next.lost = pkt.frame_lost;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= pkt.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && pkt.valid)
        begin
            data_reg <= data_next;
        end
    end

    assign st_valid = valid_reg;
    assign st_data  = data_reg;

endmodule

// ===== rtl/rcsb_scale.sv =====
// Scale stages: offset, reciprocal multiply, clamp to 0..2047.
module rcsb_scale
    import rcsb_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   in_valid,
    output logic   in_ready,
    input  front_t in_data,
    output logic   out_valid,
    input  logic   out_ready,
    output chan_t  out_data
);

    typedef struct packed {
        logic [ANALOG_CH-1:0][QPROD_W-1:0] qprod;
        logic [ANALOG_CH-1:0]              neg;
        logic [ANALOG_CH-1:0]              sw;
        logic                              lost;
    } recip_t;

    logic   mul_valid_reg;
    logic   out_valid_reg;
    logic   mul_adv;
    logic   out_adv;
    recip_t mul_reg;
    recip_t mul_next;
    chan_t  out_reg;
    chan_t  out_next;

    logic [ANALOG_CH-1:0][PROD_W-1:0]     diff;
    logic [ANALOG_CH-1:0][QPROD_W-RECIP_SHIFT-1:0] quot;

    assign out_adv  = !out_valid_reg || out_ready;
    assign mul_adv  = !mul_valid_reg || out_adv;
    assign in_ready = mul_adv;

    always_comb
    begin
        for (int i = 0; i < ANALOG_CH; i++)
        begin
            diff[i]           = in_data.prod[i] - SCALE_SUB;
            mul_next.neg[i]   = in_data.prod[i] < SCALE_SUB;
            mul_next.qprod[i] = {{RECIP_W{1'b0}}, diff[i]} *
                                {{PROD_W{1'b0}}, RECIP_MUL};
        end
        mul_next.sw   = in_data.sw;
        mul_next.lost = in_data.lost;
    end

    always_comb
    begin
        for (int i = 0; i < ANALOG_CH; i++)
        begin
            quot[i] = mul_reg.qprod[i][QPROD_W-1:RECIP_SHIFT];
            priority if (mul_reg.neg[i])
                out_next.chan[i] = '0;
            else if (quot[i] > {1'b0, CHAN_MAX})
                out_next.chan[i] = CHAN_MAX;
            else
                out_next.chan[i] = quot[i][CHAN_W-1:0];
        end
        out_next.sw   = mul_reg.sw;
        out_next.lost = mul_reg.lost;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (mul_adv)
            begin
                mul_valid_reg <= in_valid;
            end
            if (out_adv)
            begin
                out_valid_reg <= mul_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (mul_adv && in_valid)
        begin
            mul_reg <= mul_next;
        end
        if (out_adv && mul_valid_reg)
        begin
            out_reg <= out_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

// ===== rtl/rcsb_framer.sv =====
// Frame assembly and byte serialiser with registered output word.
module rcsb_framer
    import rcsb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  chan_t       in_data,
    input  logic [7:0]  sync_byte,
    input  logic [7:0]  lost_flag_mask,
    rcsb_byte_if.source frm,
    output ser_status_t status
);

    localparam logic [POS_W-1:0] LAST_POS = POS_W'(FRAME_BYTES - 1);

    logic [7:0]        frame_reg [FRAME_BYTES];
    logic [7:0]        frame_next [FRAME_BYTES];
    logic [PACK_W-1:0] packed_bits;
    logic              busy_reg;
    logic              busy_next;
    logic [POS_W-1:0]  pos_reg;
    logic [POS_W-1:0]  pos_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [7:0]        out_byte_reg;
    logic              last_reg;
    logic              emit;
    logic              emit_last;
    logic              load;

    assign emit      = busy_reg && (!out_valid_reg || frm.ready);
    assign emit_last = emit && (pos_reg == LAST_POS);
    assign in_ready  = !busy_reg || emit_last;
    assign load      = in_valid && in_ready;

    always_comb
    begin
        packed_bits = '0;
        for (int i = 0; i < ANALOG_CH; i++)
        begin
            packed_bits[i*CHAN_W +: CHAN_W] = in_data.chan[i];
            packed_bits[(i+ANALOG_CH)*CHAN_W +: CHAN_W] =
                in_data.sw[i] ? SWITCH_ON : SWITCH_OFF;
        end
        for (int k = 0; k < FRAME_BYTES; k++)
        begin
            frame_next[k] = '0;
        end
        frame_next[0] = sync_byte;
        for (int k = 0; k < PACK_W / 8; k++)
        begin
            frame_next[k+1] = packed_bits[k*8 +: 8];
        end
        frame_next[FLAG_INDEX] = in_data.lost ? lost_flag_mask : 8'd0;
    end

    always_comb
    begin
        busy_next = busy_reg;
        pos_next  = pos_reg;
        if (emit)
        begin
            pos_next = pos_reg + POS_W'(1);
        end
        if (emit_last)
        begin
            busy_next = 1'b0;
            pos_next  = '0;
        end
        if (load)
        begin
            busy_next = 1'b1;
            pos_next  = '0;
        end
        out_valid_next = out_valid_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (frm.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            pos_reg       <= pos_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            for (int k = 0; k < FRAME_BYTES; k++)
            begin
                frame_reg[k] <= frame_next[k];
            end
        end
        if (emit)
        begin
            out_byte_reg <= frame_reg[pos_reg];
            last_reg     <= (pos_reg == LAST_POS);
        end
    end

    assign frm.valid     = out_valid_reg;
    assign frm.out_byte  = out_byte_reg;
    assign frm.last_byte = last_reg;
    assign status.busy   = busy_reg;
    assign status.pos    = pos_reg;

endmodule
